### hdl/sfba_pkg.sv
`timescale 1ns / 1ps

package sfba_pkg;

  // Arena geometry and allocation policy.
  localparam int GRAIN_BYTES     = 8;
  localparam int GRAIN_SHIFT     = $clog2(GRAIN_BYTES);
  localparam int ARENA_GRAINS    = 512;
  localparam int HEADER_BYTES    = 4;
  localparam int NUM_CLASSES     = 512;
  localparam int LINK_BYTES      = 8;
  localparam int MIN_BLOCK_BYTES = HEADER_BYTES + LINK_BYTES;
  localparam int WHOLE_SPAN      = 1 + (MIN_BLOCK_BYTES - 1) / GRAIN_BYTES;
  localparam int MAX_REQUEST     = NUM_CLASSES * GRAIN_BYTES - HEADER_BYTES;

  // Field and storage widths.
  localparam int GRAIN_W  = $clog2(ARENA_GRAINS);
  localparam int SIZE_W   = GRAIN_W + 1;
  localparam int LINK_W   = SIZE_W;
  localparam int CLASS_W  = $clog2(NUM_CLASSES);
  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 12;
  localparam int BYTES_W  = 13;
  localparam int STATUS_W = 3;

  // Two-level occupancy bitmap over the class lists.
  localparam int BM_BITS   = 32;
  localparam int BM_SEL_W  = $clog2(BM_BITS);
  localparam int BM_WORDS  = NUM_CLASSES / BM_BITS;
  localparam int BM_IDX_W  = $clog2(BM_WORDS);

  typedef logic [GRAIN_W-1:0] grain_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [CLASS_W-1:0] class_t;

  localparam link_t LINK_NULL = '1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_NO_MEM   = 3'd3,
    ST_BAD_FREE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_CHECK,
    S_A_BIT,
    S_A_HEAD,
    S_A_SPLIT,
    S_A_SPLIT2,
    S_A_FIN,
    S_F_CHECK,
    S_F_TEST,
    S_F_DOWN,
    S_F_DOWN_TEST,
    S_F_DOWN_MERGE,
    S_F_UP,
    S_F_UP_TEST,
    S_F_UP_MERGE,
    S_F_TAIL,
    S_F_FIN,
    S_UL_READ,
    S_UL_GET,
    S_UL_FIX,
    S_PU_READ,
    S_PU_WRITE,
    S_PU_LINK,
    S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_ALLOC_CHECK,
    OP_FIND_BIT,
    OP_TAKE_HEAD,
    OP_WHOLE,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_ALLOC_FIN,
    OP_FREE_CHECK,
    OP_FREE_TEST,
    OP_DOWN_CHECK,
    OP_DOWN_TEST,
    OP_DOWN_MERGE,
    OP_UP_CHECK,
    OP_UP_TEST,
    OP_UP_MERGE,
    OP_FREE_TAIL,
    OP_FREE_FIN,
    OP_UL_READ,
    OP_UL_GET,
    OP_UL_FIX,
    OP_PU_READ,
    OP_PU_WRITE,
    OP_PU_LINK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   publish;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic req_big;
    logic fit_none;
    logic is_free;
    logic do_split;
    logic misaligned;
    logic nbr_alloc;
    logic nbr_empty;
    logic down_ok;
    logic up_in;
    logic clr_last;
    logic out_free;
  } stat_t;

  // Size class of a block of g grains; oversized blocks share the top class.
  function automatic class_t class_of(size_t g);
    size_t d;
    d = g - size_t'(1);
    if (g == '0) begin
      return '0;
    end else if (d >= size_t'(NUM_CLASSES)) begin
      return class_t'(NUM_CLASSES - 1);
    end else begin
      return d[CLASS_W-1:0];
    end
  endfunction

  function automatic logic link_valid(link_t l);
    return l < link_t'(ARENA_GRAINS);
  endfunction

endpackage

### hdl/sfba_if.sv
`timescale 1ns / 1ps

interface sfba_req_if import sfba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [REQ_W-1:0]   request_bytes;
  logic [ADDR_W-1:0]  block_address;

  modport source (output valid, command, request_bytes, block_address, input ready);
  modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

interface sfba_rsp_if import sfba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;
  logic [BYTES_W-1:0]  granted_bytes;
  logic [BYTES_W-1:0]  in_use_bytes;

  modport source (output valid, granted_address, status, granted_bytes, in_use_bytes,
                  input ready);
  modport sink   (input valid, granted_address, status, granted_bytes, in_use_bytes,
                  output ready);
endinterface

### hdl/sfba_ram.sv
`timescale 1ns / 1ps

module sfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sfba_ctrl.sv
`timescale 1ns / 1ps

module sfba_ctrl import sfba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  state_e ul_ret_q, pu_ret_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:        if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:         if (in_valid_i) state_d = S_DECODE;
      S_DECODE:       state_d = stat_i.is_free ? S_F_CHECK : S_A_CHECK;
      S_A_CHECK: begin
        if (stat_i.req_zero || stat_i.req_big || stat_i.fit_none) begin
          state_d = S_OUT;
        end else begin
          state_d = S_A_BIT;
        end
      end
      S_A_BIT:        state_d = S_A_HEAD;
      S_A_HEAD:       state_d = S_UL_READ;
      S_A_SPLIT:      state_d = stat_i.do_split ? S_A_SPLIT2 : S_A_FIN;
      S_A_SPLIT2:     state_d = S_PU_READ;
      S_A_FIN:        state_d = S_OUT;
      S_F_CHECK:      state_d = stat_i.misaligned ? S_OUT : S_F_TEST;
      S_F_TEST:       state_d = stat_i.nbr_alloc ? S_F_DOWN : S_OUT;
      S_F_DOWN:       state_d = stat_i.down_ok ? S_F_DOWN_TEST : S_F_UP;
      S_F_DOWN_TEST:  state_d = stat_i.nbr_alloc ? S_F_UP : S_UL_READ;
      S_F_DOWN_MERGE: state_d = S_F_DOWN;
      S_F_UP:         state_d = stat_i.up_in ? S_F_UP_TEST : S_F_TAIL;
      S_F_UP_TEST: begin
        if (stat_i.nbr_alloc || stat_i.nbr_empty) begin
          state_d = S_F_TAIL;
        end else begin
          state_d = S_UL_READ;
        end
      end
      S_F_UP_MERGE:   state_d = S_F_UP;
      S_F_TAIL:       state_d = S_PU_READ;
      S_F_FIN:        state_d = S_OUT;
      S_UL_READ:      state_d = S_UL_GET;
      S_UL_GET:       state_d = S_UL_FIX;
      S_UL_FIX:       state_d = ul_ret_q;
      S_PU_READ:      state_d = S_PU_WRITE;
      S_PU_WRITE:     state_d = S_PU_LINK;
      S_PU_LINK:      state_d = pu_ret_q;
      S_OUT:          if (stat_i.out_free) state_d = S_IDLE;
      default:        state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.publish = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      S_CLEAR:        cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_valid_i ? OP_LOAD : OP_NONE;
      end
      S_A_CHECK:      cmd_o.op = OP_ALLOC_CHECK;
      S_A_BIT:        cmd_o.op = OP_FIND_BIT;
      S_A_HEAD:       cmd_o.op = OP_TAKE_HEAD;
      S_A_SPLIT:      cmd_o.op = stat_i.do_split ? OP_SPLIT1 : OP_WHOLE;
      S_A_SPLIT2:     cmd_o.op = OP_SPLIT2;
      S_A_FIN:        cmd_o.op = OP_ALLOC_FIN;
      S_F_CHECK:      cmd_o.op = OP_FREE_CHECK;
      S_F_TEST:       cmd_o.op = OP_FREE_TEST;
      S_F_DOWN:       cmd_o.op = OP_DOWN_CHECK;
      S_F_DOWN_TEST:  cmd_o.op = OP_DOWN_TEST;
      S_F_DOWN_MERGE: cmd_o.op = OP_DOWN_MERGE;
      S_F_UP:         cmd_o.op = OP_UP_CHECK;
      S_F_UP_TEST:    cmd_o.op = OP_UP_TEST;
      S_F_UP_MERGE:   cmd_o.op = OP_UP_MERGE;
      S_F_TAIL:       cmd_o.op = OP_FREE_TAIL;
      S_F_FIN:        cmd_o.op = OP_FREE_FIN;
      S_UL_READ:      cmd_o.op = OP_UL_READ;
      S_UL_GET:       cmd_o.op = OP_UL_GET;
      S_UL_FIX:       cmd_o.op = OP_UL_FIX;
      S_PU_READ:      cmd_o.op = OP_PU_READ;
      S_PU_WRITE:     cmd_o.op = OP_PU_WRITE;
      S_PU_LINK:      cmd_o.op = OP_PU_LINK;
      S_OUT:          cmd_o.publish = stat_i.out_free;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ul_ret_q <= S_IDLE;
      pu_ret_q <= S_IDLE;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_A_HEAD:      ul_ret_q <= S_A_SPLIT;
        S_F_DOWN_TEST: ul_ret_q <= S_F_DOWN_MERGE;
        S_F_UP_TEST:   ul_ret_q <= S_F_UP_MERGE;
        S_A_SPLIT2:    pu_ret_q <= S_A_FIN;
        S_F_TAIL:      pu_ret_q <= S_F_FIN;
        default: begin
        end
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted transaction not decoded");

endmodule

### hdl/sfba_dp.sv
`timescale 1ns / 1ps

module sfba_dp import sfba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                command_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [ADDR_W-1:0]   block_address_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ADDR_W-1:0]   granted_address_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTES_W-1:0]  granted_bytes_o,
  output logic [BYTES_W-1:0]  in_use_bytes_o
);

  localparam int TOT_W = REQ_W + 1;
  localparam class_t INIT_CLASS = class_t'(NUM_CLASSES - 1);

  // Memory ports.
  logic   grains_we, alloc_we, prior_we, next_we, plink_we, head_we;
  grain_t grains_wa, alloc_wa, prior_wa, next_wa, plink_wa;
  class_t head_wa, head_ra;
  size_t  grains_wd, prior_wd;
  link_t  next_wd, plink_wd, head_wd;
  logic   alloc_wd;
  grain_t grains_ra, alloc_ra, prior_ra, next_ra, plink_ra;
  size_t  grains_rd, prior_rd;
  link_t  next_rd, plink_rd, head_rd;
  logic   alloc_rd;

  // Registers.
  logic                  is_free_q;
  logic [REQ_W-1:0]      req_q;
  logic [ADDR_W-1:0]     addr_q;
  class_t                n_q, cls_q, uc_q;
  size_t                 need_q;
  logic [BM_IDX_W-1:0]   word_q;
  grain_t                u_q, w_q, g_q, p_q;
  size_t                 s_u_q, wsz_q, gsz_q, psz_q, pprior_q, pt_q, t_q;
  link_t                 nx_q, pv_q, h_q;
  logic [ADDR_W-1:0]     res_addr_q, out_addr_q;
  status_e               res_status_q, out_status_q;
  logic [BYTES_W-1:0]    res_bytes_q, out_bytes_q, out_in_use_q;
  logic                  out_valid_q;
  logic [BYTES_W-1:0]    in_use_q;
  grain_t                clr_q;
  logic [BM_BITS-1:0]    bm_q [BM_WORDS];

  // Request sizing.
  logic [TOT_W-1:0]    tot, tot_c, n_wide;
  class_t              n_c;
  size_t               need_c;
  logic                req_zero, req_big;
  always_comb begin
    tot    = TOT_W'(req_q) + TOT_W'(HEADER_BYTES);
    tot_c  = (tot < TOT_W'(MIN_BLOCK_BYTES)) ? TOT_W'(MIN_BLOCK_BYTES) : tot;
    n_wide = (tot_c - TOT_W'(1)) >> GRAIN_SHIFT;
    n_c    = n_wide[CLASS_W-1:0];
    need_c = size_t'(n_c) + size_t'(1);
    req_zero = (req_q == '0);
    req_big  = (req_q > REQ_W'(MAX_REQUEST));
  end

  // First level of the class search: lowest nonempty word at or above the start word.
  // In the start word only classes at or above the request's class count.
  logic [BM_WORDS-1:0] summ;
  logic [BM_IDX_W-1:0] word_lo, word_sel;
  logic                word_found;
  logic [BM_BITS-1:0]  lo_mask;
  always_comb begin
    word_lo    = n_c[CLASS_W-1 -: BM_IDX_W];
    lo_mask    = '1 << n_c[BM_SEL_W-1:0];
    word_sel   = '0;
    word_found = 1'b0;
    for (int w = 0; w < BM_WORDS; w++) begin
      if (BM_IDX_W'(w) == word_lo) begin
        summ[w] = |(bm_q[w] & lo_mask);
      end else begin
        summ[w] = |bm_q[w];
      end
    end
    for (int w = BM_WORDS - 1; w >= 0; w--) begin
      if (summ[w] && (BM_IDX_W'(w) >= word_lo)) begin
        word_sel   = BM_IDX_W'(w);
        word_found = 1'b1;
      end
    end
  end

  // Second level: lowest set bit within the chosen word.
  logic [BM_BITS-1:0]  wbits;
  logic [BM_SEL_W-1:0] bit_sel;
  class_t              cls_c;
  always_comb begin
    wbits = bm_q[word_q];
    if (word_q == n_q[CLASS_W-1 -: BM_IDX_W]) begin
      for (int i = 0; i < BM_BITS; i++) begin
        if (BM_SEL_W'(i) < n_q[BM_SEL_W-1:0]) begin
          wbits[i] = 1'b0;
        end
      end
    end
    bit_sel = '0;
    for (int i = BM_BITS - 1; i >= 0; i--) begin
      if (wbits[i]) begin
        bit_sel = BM_SEL_W'(i);
      end
    end
    cls_c = {word_q, bit_sel};
  end

  // Split arithmetic and neighbor addresses.
  size_t  q_c, rem_c, down_t, up_t, merged_c;
  grain_t g_split;
  class_t push_cls;
  logic   push_ne;
  link_t  h_c;
  logic [BYTES_W-1:0] freed_c;
  always_comb begin
    q_c      = size_t'(u_q) + s_u_q;
    rem_c    = s_u_q - need_q;
    g_split  = grain_t'(q_c - need_q);
    down_t   = size_t'(p_q) - pprior_q;
    up_t     = size_t'(p_q) + psz_q;
    merged_c = s_u_q + psz_q;
    push_cls = class_of(wsz_q);
    push_ne  = bm_q[push_cls[CLASS_W-1 -: BM_IDX_W]][push_cls[BM_SEL_W-1:0]];
    h_c      = push_ne ? head_rd : LINK_NULL;
    freed_c  = BYTES_W'(grains_rd) << GRAIN_SHIFT;
  end

  always_comb begin
    stat_o.req_zero   = req_zero;
    stat_o.req_big    = req_big;
    stat_o.fit_none   = !word_found;
    stat_o.is_free    = is_free_q;
    stat_o.do_split   = !((size_t'(cls_q) < size_t'(n_q) + size_t'(WHOLE_SPAN)) ||
                          (s_u_q <= need_q));
    stat_o.misaligned = (addr_q[GRAIN_SHIFT-1:0] != '0);
    stat_o.nbr_alloc  = alloc_rd;
    stat_o.nbr_empty  = (grains_rd == '0);
    stat_o.down_ok    = (pprior_q != '0) && (pprior_q <= size_t'(p_q));
    stat_o.up_in      = (up_t < size_t'(ARENA_GRAINS));
    stat_o.clr_last   = (clr_q == '1);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Memory control per operation.
  always_comb begin
    grains_we = 1'b0; grains_wa = '0; grains_wd = '0; grains_ra = '0;
    alloc_we  = 1'b0; alloc_wa  = '0; alloc_wd  = 1'b0; alloc_ra = '0;
    prior_we  = 1'b0; prior_wa  = '0; prior_wd  = '0; prior_ra = '0;
    next_we   = 1'b0; next_wa   = '0; next_wd   = '0; next_ra  = '0;
    plink_we  = 1'b0; plink_wa  = '0; plink_wd  = '0; plink_ra = '0;
    head_we   = 1'b0; head_wa   = '0; head_wd   = '0; head_ra  = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        grains_we = 1'b1; grains_wa = clr_q;
        grains_wd = (clr_q == '0) ? size_t'(ARENA_GRAINS) : '0;
        alloc_we  = 1'b1; alloc_wa  = clr_q;
        prior_we  = 1'b1; prior_wa  = clr_q;
        next_we   = 1'b1; next_wa   = clr_q; next_wd  = LINK_NULL;
        plink_we  = 1'b1; plink_wa  = clr_q; plink_wd = LINK_NULL;
        head_we   = 1'b1; head_wa   = class_t'(clr_q);
        head_wd   = (class_t'(clr_q) == INIT_CLASS) ? '0 : LINK_NULL;
      end
      OP_FIND_BIT: head_ra = cls_c;
      OP_UL_READ: begin
        grains_ra = u_q;
        next_ra   = u_q;
        plink_ra  = u_q;
      end
      OP_UL_GET: begin
        if (link_valid(next_rd)) begin
          plink_we = 1'b1; plink_wa = next_rd[GRAIN_W-1:0]; plink_wd = plink_rd;
        end
      end
      OP_UL_FIX: begin
        if (link_valid(pv_q)) begin
          next_we = 1'b1; next_wa = pv_q[GRAIN_W-1:0]; next_wd = nx_q;
        end else begin
          head_we = 1'b1; head_wa = uc_q;
          head_wd = link_valid(nx_q) ? nx_q : LINK_NULL;
        end
      end
      OP_PU_READ: head_ra = push_cls;
      OP_PU_WRITE: begin
        next_we  = 1'b1; next_wa  = w_q; next_wd  = h_c;
        plink_we = 1'b1; plink_wa = w_q; plink_wd = LINK_NULL;
        head_we  = 1'b1; head_wa  = push_cls; head_wd = link_t'(w_q);
      end
      OP_PU_LINK: begin
        if (link_valid(h_q)) begin
          plink_we = 1'b1; plink_wa = h_q[GRAIN_W-1:0]; plink_wd = link_t'(w_q);
        end
      end
      OP_SPLIT1: begin
        grains_we = 1'b1; grains_wa = u_q;     grains_wd = rem_c;
        prior_we  = 1'b1; prior_wa  = g_split; prior_wd  = rem_c;
      end
      OP_SPLIT2: begin
        grains_we = 1'b1; grains_wa = g_q; grains_wd = need_q;
        if (q_c < size_t'(ARENA_GRAINS)) begin
          prior_we = 1'b1; prior_wa = q_c[GRAIN_W-1:0]; prior_wd = need_q;
        end
      end
      OP_ALLOC_FIN: begin
        alloc_we = 1'b1; alloc_wa = g_q; alloc_wd = 1'b1;
      end
      OP_FREE_CHECK: begin
        alloc_ra  = addr_q[GRAIN_SHIFT +: GRAIN_W];
        grains_ra = addr_q[GRAIN_SHIFT +: GRAIN_W];
        prior_ra  = addr_q[GRAIN_SHIFT +: GRAIN_W];
      end
      OP_FREE_TEST: begin
        if (alloc_rd) begin
          alloc_we = 1'b1; alloc_wa = addr_q[GRAIN_SHIFT +: GRAIN_W];
        end
      end
      OP_DOWN_CHECK: begin
        alloc_ra = down_t[GRAIN_W-1:0];
        prior_ra = down_t[GRAIN_W-1:0];
      end
      OP_DOWN_MERGE: begin
        grains_we = 1'b1; grains_wa = t_q[GRAIN_W-1:0]; grains_wd = merged_c;
      end
      OP_UP_CHECK: begin
        alloc_ra  = up_t[GRAIN_W-1:0];
        grains_ra = up_t[GRAIN_W-1:0];
      end
      OP_UP_MERGE: begin
        grains_we = 1'b1; grains_wa = p_q; grains_wd = merged_c;
      end
      OP_FREE_TAIL: begin
        if (up_t < size_t'(ARENA_GRAINS)) begin
          prior_we = 1'b1; prior_wa = up_t[GRAIN_W-1:0]; prior_wd = psz_q;
        end
      end
      default: begin
      end
    endcase
  end

  sfba_ram #(.WIDTH(SIZE_W), .DEPTH(ARENA_GRAINS)) u_grains (
    .clk_i, .we_i(grains_we), .waddr_i(grains_wa), .wdata_i(grains_wd),
    .raddr_i(grains_ra), .rdata_o(grains_rd)
  );
  sfba_ram #(.WIDTH(1), .DEPTH(ARENA_GRAINS)) u_alloc (
    .clk_i, .we_i(alloc_we), .waddr_i(alloc_wa), .wdata_i(alloc_wd),
    .raddr_i(alloc_ra), .rdata_o(alloc_rd)
  );
  sfba_ram #(.WIDTH(SIZE_W), .DEPTH(ARENA_GRAINS)) u_prior (
    .clk_i, .we_i(prior_we), .waddr_i(prior_wa), .wdata_i(prior_wd),
    .raddr_i(prior_ra), .rdata_o(prior_rd)
  );
  sfba_ram #(.WIDTH(LINK_W), .DEPTH(ARENA_GRAINS)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(next_ra), .rdata_o(next_rd)
  );
  sfba_ram #(.WIDTH(LINK_W), .DEPTH(ARENA_GRAINS)) u_plink (
    .clk_i, .we_i(plink_we), .waddr_i(plink_wa), .wdata_i(plink_wd),
    .raddr_i(plink_ra), .rdata_o(plink_rd)
  );
  sfba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CLASSES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );

  // Control state: output valid, byte count, sweep counter, class bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      in_use_q    <= '0;
      clr_q       <= '0;
      for (int w = 0; w < BM_WORDS; w++) begin
        bm_q[w] <= '0;
      end
      bm_q[INIT_CLASS[CLASS_W-1 -: BM_IDX_W]][INIT_CLASS[BM_SEL_W-1:0]] <= 1'b1;
    end else begin
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR:     clr_q <= clr_q + grain_t'(1);
        OP_ALLOC_FIN: in_use_q <= in_use_q + (BYTES_W'(gsz_q) << GRAIN_SHIFT);
        OP_FREE_TEST: begin
          if (alloc_rd) begin
            in_use_q <= (in_use_q >= freed_c) ? in_use_q - freed_c : '0;
          end
        end
        OP_UL_FIX: begin
          if (!link_valid(pv_q)) begin
            bm_q[uc_q[CLASS_W-1 -: BM_IDX_W]][uc_q[BM_SEL_W-1:0]] <= link_valid(nx_q);
          end
        end
        OP_PU_WRITE: bm_q[push_cls[CLASS_W-1 -: BM_IDX_W]][push_cls[BM_SEL_W-1:0]] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_bytes_q  <= res_bytes_q;
      out_in_use_q <= in_use_q;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        is_free_q    <= (cmd_e'(command_i) == CMD_FREE);
        req_q        <= request_bytes_i;
        addr_q       <= block_address_i;
        res_addr_q   <= '0;
        res_bytes_q  <= '0;
        res_status_q <= ST_OK;
      end
      OP_ALLOC_CHECK: begin
        n_q    <= n_c;
        need_q <= need_c;
        word_q <= word_sel;
        if (req_zero) begin
          res_status_q <= ST_ZERO;
        end else if (req_big) begin
          res_status_q <= ST_TOO_BIG;
        end else if (!word_found) begin
          res_status_q <= ST_NO_MEM;
        end
      end
      OP_FIND_BIT:  cls_q <= cls_c;
      OP_TAKE_HEAD: u_q <= head_rd[GRAIN_W-1:0];
      OP_UL_GET: begin
        s_u_q <= grains_rd;
        nx_q  <= next_rd;
        pv_q  <= plink_rd;
        uc_q  <= class_of(grains_rd);
      end
      OP_PU_WRITE:  h_q <= h_c;
      OP_WHOLE: begin
        g_q   <= u_q;
        gsz_q <= s_u_q;
      end
      OP_SPLIT1: begin
        g_q   <= g_split;
        gsz_q <= need_q;
      end
      OP_SPLIT2: begin
        w_q   <= u_q;
        wsz_q <= rem_c;
      end
      OP_ALLOC_FIN: begin
        res_addr_q  <= ADDR_W'(g_q) << GRAIN_SHIFT;
        res_bytes_q <= BYTES_W'(gsz_q) << GRAIN_SHIFT;
      end
      OP_FREE_CHECK: begin
        if (addr_q[GRAIN_SHIFT-1:0] != '0) begin
          res_status_q <= ST_BAD_FREE;
        end
      end
      OP_FREE_TEST: begin
        p_q      <= addr_q[GRAIN_SHIFT +: GRAIN_W];
        psz_q    <= grains_rd;
        pprior_q <= prior_rd;
        if (!alloc_rd) begin
          res_status_q <= ST_BAD_FREE;
        end
      end
      OP_DOWN_CHECK: t_q <= down_t;
      OP_DOWN_TEST: begin
        pt_q <= prior_rd;
        u_q  <= t_q[GRAIN_W-1:0];
      end
      OP_DOWN_MERGE: begin
        p_q      <= t_q[GRAIN_W-1:0];
        psz_q    <= merged_c;
        pprior_q <= pt_q;
      end
      OP_UP_CHECK:  t_q <= up_t;
      OP_UP_TEST:   u_q <= t_q[GRAIN_W-1:0];
      OP_UP_MERGE:  psz_q <= merged_c;
      OP_FREE_TAIL: begin
        w_q   <= p_q;
        wsz_q <= psz_q;
      end
      OP_FREE_FIN: begin
        res_addr_q  <= ADDR_W'(p_q) << GRAIN_SHIFT;
        res_bytes_q <= BYTES_W'(psz_q) << GRAIN_SHIFT;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;
  assign granted_bytes_o   = out_bytes_q;
  assign in_use_bytes_o    = out_in_use_q;

  a_publish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_q)
    else $error("published result not presented");

  a_in_use_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= BYTES_W'(ARENA_GRAINS * GRAIN_BYTES))
    else $error("allocated byte count exceeds arena");

endmodule

### hdl/segregated_fit_block_allocator.sv
`timescale 1ns / 1ps

// Segregated-fit block allocator over a 512-grain arena of 8-byte grains.
// The request channel carries one transaction per operation: an allocate of
// request_bytes, or a free of the block at block_address. The result channel
// returns exactly one transaction per request: the granted or merged block's
// address and size in bytes, a status code, and the bytes in use afterward.
// Operations run one at a time through a controller that sequences reads and
// writes of six memories with one read and one write port each (block sizes,
// allocated flags, lower neighbor sizes, forward and backward list links, list
// heads). An allocate unlinks the found block and, when it splits the block,
// pushes the remainder; a rejected request, a misaligned free or a free of a
// block that is not allocated ends early. A free examines each neighbor in
// turn, unlinks and merges each free one, and pushes the merged block. Each
// list unlink reads the block, gets its links and fixes them; each push reads
// the list head, writes the block's links and links the old head back. The
// next request is accepted at the earliest in the cycle after the result is
// published. After reset a clearing pass initializes the memories; no
// request is accepted during it. Results sit in an output register: the
// block accepts the next request while a result waits, and holds a finished
// result until the receiver takes the previous one.
module segregated_fit_block_allocator import sfba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfba_req_if.sink    req_i,
  sfba_rsp_if.source  rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: owns the sequencing and the request handshake.
  sfba_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: memories, class bitmap, working registers and result register.
  sfba_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i             (cmd),
    .stat_o            (stat),
    .command_i         (req_i.command),
    .request_bytes_i   (req_i.request_bytes),
    .block_address_i   (req_i.block_address),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .granted_address_o (rsp_o.granted_address),
    .status_o          (rsp_o.status),
    .granted_bytes_o   (rsp_o.granted_bytes),
    .in_use_bytes_o    (rsp_o.in_use_bytes)
  );

endmodule
